### design/soq_pkg.sv
// ----------------------------------------------------------------------------
// soq_pkg
// Shared types, sizes and codes of the sphere occupancy query core.
// ----------------------------------------------------------------------------
package soq_pkg;

	localparam int OBSTACLE_SLOTS = 256;
	localparam int SENSOR_SLOTS   = 64;

	localparam int OBS_CNT_W = $clog2(OBSTACLE_SLOTS + 1);
	localparam int SEN_CNT_W = $clog2(SENSOR_SLOTS + 1);

	// one rotation step per cycle, long enough for the bigger ring
	localparam int SCAN_LEN = (OBSTACLE_SLOTS > SENSOR_SLOTS) ? OBSTACLE_SLOTS : SENSOR_SLOTS;
	localparam int STEP_W   = $clog2(SCAN_LEN);

	// pipeline drain from ring head to the finished compare flags
	localparam int WAIT_CYCLES = 6;
	localparam int WAIT_W      = $clog2(WAIT_CYCLES);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		ACT_ADD_OBS = 2'd0,
		ACT_ADD_SEN = 2'd1,
		ACT_POINT   = 2'd2,
		ACT_BOX     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OCC_FREE     = 2'd0,
		OCC_UNKNOWN  = 2'd1,
		OCC_OCCUPIED = 2'd2
	} occ_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WORLD_LOW_X  = 3'd0,
		REG_WORLD_LOW_Y  = 3'd1,
		REG_WORLD_LOW_Z  = 3'd2,
		REG_WORLD_HIGH_X = 3'd3,
		REG_WORLD_HIGH_Y = 3'd4,
		REG_WORLD_HIGH_Z = 3'd5,
		REG_MATCH_EPS    = 3'd6,
		REG_MAP_READY    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [14:0]        r;
	} sphere_t;

	// verdict of one table scan on its nearest sphere
	typedef struct packed {
		logic found;
		logic hit;
		logic overlap;
		logic dup;
	} scan_res_t;

	typedef struct packed {
		occ_t occupancy;
		logic inserted;
		logic table_full;
	} result_t;

endpackage

### design/soq_if.sv
// ----------------------------------------------------------------------------
// soq channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface soq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic [14:0]        radius;
	logic [14:0]        half_x;
	logic [14:0]        half_y;
	logic [14:0]        half_z;

	modport source (output valid, action, pos_x, pos_y, pos_z, radius, half_x, half_y,
		half_z, input ready);
	modport sink (input valid, action, pos_x, pos_y, pos_z, radius, half_x, half_y,
		half_z, output ready);
endinterface

interface soq_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] occupancy;
	logic       inserted;
	logic       table_full;

	modport source (output valid, occupancy, inserted, table_full, input ready);
	modport sink (input valid, occupancy, inserted, table_full, output ready);
endinterface

interface soq_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [soq_pkg::CFG_IDX_W-1:0]     index;
	logic [soq_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/soq_cell.sv
// ----------------------------------------------------------------------------
// soq_cell
// One sphere slot of a rotating table; takes its neighbor's sphere on shift.
// ----------------------------------------------------------------------------
module soq_cell (
	input  logic             clk,
	input  logic             shift,
	input  soq_pkg::sphere_t d,
	output soq_pkg::sphere_t q
);

	soq_pkg::sphere_t sphere_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			sphere_q <= d;
		end
	end

	assign q = sphere_q;

endmodule

### design/soq_scan.sv
// ----------------------------------------------------------------------------
// soq_scan
// Nearest-center tracker fed by a ring head, plus the final sphere tests.
// ----------------------------------------------------------------------------
module soq_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  head_valid,
	input  soq_pkg::sphere_t      head,
	input  logic signed [15:0]    pos_x,
	input  logic signed [15:0]    pos_y,
	input  logic signed [15:0]    pos_z,
	input  logic [14:0]           radius,
	input  logic [14:0]           half_x,
	input  logic [14:0]           half_y,
	input  logic [14:0]           half_z,
	input  logic [31:0]           epsilon,
	output soq_pkg::scan_res_t    res
);

	// distance from clamped box point to the center along one axis
	function automatic logic signed [17:0] clamp_gap(input logic signed [15:0] p,
			input logic [14:0] h, input logic signed [15:0] c);
		logic signed [17:0] lo;
		logic signed [17:0] hi;
		logic signed [17:0] cc;
		logic signed [17:0] v;
		lo = 18'(p) - $signed({3'b000, h});
		hi = 18'(p) + $signed({3'b000, h});
		cc = 18'(c);
		v  = (cc > lo) ? cc : lo;
		v  = (v < hi) ? v : hi;
		return cc - v;
	endfunction

	logic                valid_s1;
	logic signed [16:0]  dx_s1, dy_s1, dz_s1;
	soq_pkg::sphere_t    sph_s1;
	logic                valid_s2;
	logic [31:0]         sqx_s2, sqy_s2, sqz_s2;
	soq_pkg::sphere_t    sph_s2;

	logic                found_q;
	logic [33:0]         best_d_q;
	soq_pkg::sphere_t    best_q;

	logic signed [17:0]  ex_f1, ey_f1, ez_f1;
	logic [14:0]         adr_f1;
	logic [33:0]         d2_f1;
	logic [14:0]         r_f1;
	logic                found_f1;

	logic [33:0]         bx_f2, by_f2, bz_f2;
	logic [29:0]         r2_f2;
	logic [33:0]         d2_f2;
	logic [14:0]         adr_f2;
	logic                found_f2;

	soq_pkg::scan_res_t  res_q;

	logic signed [33:0]  pxx, pyy, pzz;
	logic [33:0]         d2_new;
	logic signed [15:0]  dr;
	logic signed [35:0]  qbx, qby, qbz;
	logic [35:0]         box_d2;

	assign pxx    = dx_s1 * dx_s1;
	assign pyy    = dy_s1 * dy_s1;
	assign pzz    = dz_s1 * dz_s1;
	assign d2_new = {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
	assign dr     = $signed({1'b0, radius}) - $signed({1'b0, best_q.r});
	assign qbx    = ex_f1 * ex_f1;
	assign qby    = ey_f1 * ey_f1;
	assign qbz    = ez_f1 * ez_f1;
	assign box_d2 = {2'b00, bx_f2} + {2'b00, by_f2} + {2'b00, bz_f2};

	// distance pipeline, payload only
	always_ff @(posedge clk) begin
		dx_s1  <= 17'(head.x) - 17'(pos_x);
		dy_s1  <= 17'(head.y) - 17'(pos_y);
		dz_s1  <= 17'(head.z) - 17'(pos_z);
		sph_s1 <= head;
		sqx_s2 <= pxx[31:0];
		sqy_s2 <= pyy[31:0];
		sqz_s2 <= pzz[31:0];
		sph_s2 <= sph_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			if (clear) begin
				found_q <= 1'b0;
			end else if (valid_s2 && (!found_q || d2_new < best_d_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	// strict less keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (valid_s2 && (!found_q || d2_new < best_d_q)) begin
			best_d_q <= d2_new;
			best_q   <= sph_s2;
		end
	end

	// final tests on the winner, recomputed every cycle
	always_ff @(posedge clk) begin
		ex_f1    <= clamp_gap(pos_x, half_x, best_q.x);
		ey_f1    <= clamp_gap(pos_y, half_y, best_q.y);
		ez_f1    <= clamp_gap(pos_z, half_z, best_q.z);
		adr_f1   <= dr[15] ? 15'(-dr) : dr[14:0];
		d2_f1    <= best_d_q;
		r_f1     <= best_q.r;
		found_f1 <= found_q;

		bx_f2    <= qbx[33:0];
		by_f2    <= qby[33:0];
		bz_f2    <= qbz[33:0];
		r2_f2    <= r_f1 * r_f1;
		d2_f2    <= d2_f1;
		adr_f2   <= adr_f1;
		found_f2 <= found_f1;

		res_q.found   <= found_f2;
		res_q.hit     <= found_f2 && (d2_f2 < {4'b0000, r2_f2});
		res_q.overlap <= found_f2 && (box_d2 <= {6'b000000, r2_f2});
		res_q.dup     <= found_f2 && (d2_f2 < {2'b00, epsilon})
			&& ({9'b0, adr_f2, 8'b0} < epsilon);
	end

	assign res = res_q;

endmodule

### design/sphere_occupancy_query_core.sv
// ----------------------------------------------------------------------------
// sphere_occupancy_query_core
// Obstacle and sensor-view sphere tables held in rotating cell rings, with
// nearest-center scans for de-duplicated obstacle inserts and point/box occupancy.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    action, pos_x/y/z, radius, half_x/y/z
//  rsp      out  valid/ready    occupancy, inserted, table_full
//  cfg      in   valid/ready    index, data (ready tied high)
//
//  sensor insert: one pass of the sensor ring; query or dropped obstacle insert:
//  a scan of the longer ring, the ST_WAIT drain and ST_DECIDE; stored obstacle insert
//  adds a pass of the obstacle ring. The ring turns one cell per cycle.
//  reset clears counts, registers, state; table contents need no reset.
//  a waiting response does not block taking the next request; a full
//  response register holds the core until rsp is taken.
// ----------------------------------------------------------------------------
module sphere_occupancy_query_core (
	input  logic             clk,
	input  logic             arst_n,
	soq_req_if.sink          req,
	soq_rsp_if.source        rsp,
	soq_cfg_if.sink          cfg
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_WAIT   = 6'b000100,
		ST_DECIDE = 6'b001000,
		ST_INS    = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	// configuration registers
	logic signed [15:0] low_x_q, low_y_q, low_z_q;
	logic signed [15:0] high_x_q, high_y_q, high_z_q;
	logic [31:0]        eps_q;
	logic               map_ready_q;

	// latched request
	soq_pkg::action_t   act_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic [14:0]        rad_q, hx_q, hy_q, hz_q;

	state_t                        state_q;
	logic [soq_pkg::STEP_W-1:0]    step_q;
	logic [soq_pkg::WAIT_W-1:0]    wait_q;
	logic [soq_pkg::OBS_CNT_W-1:0] obs_cnt_q;
	logic [soq_pkg::SEN_CNT_W-1:0] sen_cnt_q;
	logic                          ins_obs_q;
	soq_pkg::result_t              res_q;
	soq_pkg::result_t              out_q;
	logic                          out_valid_q;

	logic req_fire;
	logic out_load;
	logic obs_shift, sen_shift, obs_put, sen_put;
	logic obs_head_v, sen_head_v;
	logic scan_last, ins_last;
	soq_pkg::sphere_t   new_sph;
	soq_pkg::scan_res_t obs_res, sen_res;
	soq_pkg::sphere_t   obs_tap [soq_pkg::OBSTACLE_SLOTS];
	soq_pkg::sphere_t   sen_tap [soq_pkg::SENSOR_SLOTS];

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign new_sph = '{x: px_q, y: py_q, z: pz_q, r: rad_q};

	// rings turn during scans and during the insert pass of their own table
	assign obs_shift = ((state_q == ST_SCAN) || (state_q == ST_INS && ins_obs_q))
		&& (int'(step_q) < soq_pkg::OBSTACLE_SLOTS);
	assign sen_shift = ((state_q == ST_SCAN) || (state_q == ST_INS && !ins_obs_q))
		&& (int'(step_q) < soq_pkg::SENSOR_SLOTS);
	// the new sphere enters the tail just as slot count comes round
	assign obs_put = (state_q == ST_INS) && ins_obs_q && (int'(step_q) == int'(obs_cnt_q));
	assign sen_put = (state_q == ST_INS) && !ins_obs_q && (int'(step_q) == int'(sen_cnt_q));
	// only written slots reach the distance pipeline
	assign obs_head_v = (state_q == ST_SCAN) && (int'(step_q) < int'(obs_cnt_q));
	assign sen_head_v = (state_q == ST_SCAN) && (int'(step_q) < int'(sen_cnt_q));

	assign scan_last = (step_q == soq_pkg::STEP_W'(soq_pkg::SCAN_LEN - 1));
	assign ins_last  = ins_obs_q
		? (step_q == soq_pkg::STEP_W'(soq_pkg::OBSTACLE_SLOTS - 1))
		: (step_q == soq_pkg::STEP_W'(soq_pkg::SENSOR_SLOTS - 1));

	// obstacle ring: cell i takes cell i+1, the tail takes the head back
	for (genvar gi = 0; gi < soq_pkg::OBSTACLE_SLOTS; gi++) begin : g_obs
		soq_pkg::sphere_t d;
		assign d = (gi == soq_pkg::OBSTACLE_SLOTS - 1)
			? (obs_put ? new_sph : obs_tap[0])
			: obs_tap[(gi + 1) % soq_pkg::OBSTACLE_SLOTS];
		soq_cell u_cell (.clk(clk), .shift(obs_shift), .d(d), .q(obs_tap[gi]));
	end

	// sensor ring, same arrangement
	for (genvar gi = 0; gi < soq_pkg::SENSOR_SLOTS; gi++) begin : g_sen
		soq_pkg::sphere_t d;
		assign d = (gi == soq_pkg::SENSOR_SLOTS - 1)
			? (sen_put ? new_sph : sen_tap[0])
			: sen_tap[(gi + 1) % soq_pkg::SENSOR_SLOTS];
		soq_cell u_cell (.clk(clk), .shift(sen_shift), .d(d), .q(sen_tap[gi]));
	end

	soq_scan u_obs_scan (
		.clk(clk), .arst_n(arst_n), .clear(req_fire), .head_valid(obs_head_v),
		.head(obs_tap[0]), .pos_x(px_q), .pos_y(py_q), .pos_z(pz_q), .radius(rad_q),
		.half_x(hx_q), .half_y(hy_q), .half_z(hz_q), .epsilon(eps_q), .res(obs_res)
	);

	soq_scan u_sen_scan (
		.clk(clk), .arst_n(arst_n), .clear(req_fire), .head_valid(sen_head_v),
		.head(sen_tap[0]), .pos_x(px_q), .pos_y(py_q), .pos_z(pz_q), .radius(rad_q),
		.half_x(hx_q), .half_y(hy_q), .half_z(hz_q), .epsilon(eps_q), .res(sen_res)
	);

	// world limits; box queries shrink the limits by the half extents
	logic               is_box;
	logic [14:0]        ex, ey, ez;
	logic signed [17:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	logic               outside;
	soq_pkg::occ_t      occ;

	assign is_box = (act_q == soq_pkg::ACT_BOX);
	assign ex = is_box ? hx_q : '0;
	assign ey = is_box ? hy_q : '0;
	assign ez = is_box ? hz_q : '0;
	assign lo_x = 18'(low_x_q) + $signed({3'b000, ex});
	assign lo_y = 18'(low_y_q) + $signed({3'b000, ey});
	assign lo_z = 18'(low_z_q) + $signed({3'b000, ez});
	assign hi_x = 18'(high_x_q) - $signed({3'b000, ex});
	assign hi_y = 18'(high_y_q) - $signed({3'b000, ey});
	assign hi_z = 18'(high_z_q) - $signed({3'b000, ez});
	assign outside = (18'(px_q) < lo_x) || (18'(px_q) > hi_x)
		|| (18'(py_q) < lo_y) || (18'(py_q) > hi_y)
		|| (18'(pz_q) < lo_z) || (18'(pz_q) > hi_z);

	always_comb begin
		priority if (!map_ready_q) begin
			occ = soq_pkg::OCC_OCCUPIED;
		end else if (outside) begin
			occ = soq_pkg::OCC_OCCUPIED;
		end else if (!is_box) begin
			occ = obs_res.hit ? soq_pkg::OCC_OCCUPIED
				: (sen_res.hit ? soq_pkg::OCC_FREE : soq_pkg::OCC_UNKNOWN);
		end else begin
			occ = obs_res.overlap ? soq_pkg::OCC_OCCUPIED
				: (sen_res.overlap ? soq_pkg::OCC_FREE : soq_pkg::OCC_UNKNOWN);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_x_q     <= 16'sh8000;
			low_y_q     <= 16'sh8000;
			low_z_q     <= 16'sh8000;
			high_x_q    <= 16'sh7fff;
			high_y_q    <= 16'sh7fff;
			high_z_q    <= 16'sh7fff;
			eps_q       <= 32'd1;
			map_ready_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (soq_pkg::reg_idx_t'(cfg.index))
				soq_pkg::REG_WORLD_LOW_X:  low_x_q     <= cfg.data[15:0];
				soq_pkg::REG_WORLD_LOW_Y:  low_y_q     <= cfg.data[15:0];
				soq_pkg::REG_WORLD_LOW_Z:  low_z_q     <= cfg.data[15:0];
				soq_pkg::REG_WORLD_HIGH_X: high_x_q    <= cfg.data[15:0];
				soq_pkg::REG_WORLD_HIGH_Y: high_y_q    <= cfg.data[15:0];
				soq_pkg::REG_WORLD_HIGH_Z: high_z_q    <= cfg.data[15:0];
				soq_pkg::REG_MATCH_EPS:    eps_q       <= cfg.data;
				soq_pkg::REG_MAP_READY:    map_ready_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (req_fire) begin
			act_q <= soq_pkg::action_t'(req.action);
			px_q  <= req.pos_x;
			py_q  <= req.pos_y;
			pz_q  <= req.pos_z;
			rad_q <= req.radius;
			hx_q  <= req.half_x;
			hy_q  <= req.half_y;
			hz_q  <= req.half_z;
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			wait_q    <= '0;
			obs_cnt_q <= '0;
			sen_cnt_q <= '0;
			ins_obs_q <= 1'b0;
			res_q     <= '{occupancy: soq_pkg::OCC_FREE, inserted: 1'b0, table_full: 1'b0};
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (req_fire) begin
						if (soq_pkg::action_t'(req.action) == soq_pkg::ACT_ADD_SEN) begin
							ins_obs_q <= 1'b0;
							if (int'(sen_cnt_q) < soq_pkg::SENSOR_SLOTS) begin
								state_q <= ST_INS;
							end else begin
								res_q   <= '{occupancy: soq_pkg::OCC_FREE, inserted: 1'b0,
									table_full: 1'b1};
								state_q <= ST_DONE;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					step_q <= step_q + 1'b1;
					if (scan_last) begin
						wait_q  <= '0;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					wait_q <= wait_q + 1'b1;
					if (wait_q == soq_pkg::WAIT_W'(soq_pkg::WAIT_CYCLES - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					step_q <= '0;
					if (act_q == soq_pkg::ACT_ADD_OBS) begin
						if (obs_res.dup) begin
							res_q   <= '{occupancy: soq_pkg::OCC_FREE, inserted: 1'b0,
								table_full: 1'b0};
							state_q <= ST_DONE;
						end else if (int'(obs_cnt_q) < soq_pkg::OBSTACLE_SLOTS) begin
							ins_obs_q <= 1'b1;
							state_q   <= ST_INS;
						end else begin
							res_q   <= '{occupancy: soq_pkg::OCC_FREE, inserted: 1'b0,
								table_full: 1'b1};
							state_q <= ST_DONE;
						end
					end else begin
						res_q   <= '{occupancy: occ, inserted: 1'b0, table_full: 1'b0};
						state_q <= ST_DONE;
					end
				end
				ST_INS: begin
					step_q <= step_q + 1'b1;
					if (ins_last) begin
						if (ins_obs_q) begin
							obs_cnt_q <= obs_cnt_q + 1'b1;
						end else begin
							sen_cnt_q <= sen_cnt_q + 1'b1;
						end
						res_q   <= '{occupancy: soq_pkg::OCC_FREE, inserted: 1'b1,
							table_full: 1'b0};
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.occupancy  = out_q.occupancy;
	assign rsp.inserted   = out_q.inserted;
	assign rsp.table_full = out_q.table_full;

`ifndef SYNTHESIS
	a_obs_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(obs_cnt_q) <= soq_pkg::OBSTACLE_SLOTS)
		else $error("obstacle count beyond table size");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(obs_cnt_q != $past(obs_cnt_q)) |-> (obs_cnt_q == $past(obs_cnt_q) + 1'b1))
		else $error("obstacle count moved by more than one");

	a_excl_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.inserted && out_q.table_full))
		else $error("insert reported both stored and dropped");

	a_ring_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!obs_shift && !sen_shift))
		else $error("table ring turned while idle");
`endif

endmodule
